[design/chkim_pkg.sv]
package chkim_pkg;

  localparam int unsigned KeyW   = 31;
  localparam int unsigned ValueW = 10;

  typedef enum logic [1:0] {
    CmdInsert = 2'd0,
    CmdLookup = 2'd1,
    CmdClear  = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [1:0]      command;
    logic [KeyW-1:0] key;
  } in_item_t;

  typedef struct packed {
    logic              found;
    logic [ValueW-1:0] value;
    logic              full_error;
  } out_item_t;

  // control part of the token that travels down the cell row
  typedef struct packed {
    logic vld;
    logic wr;
    logic found;
    logic done;
  } tok_ctl_t;

endpackage

[design/chkim_cell.sv]
module chkim_cell #(
  parameter int unsigned SlotW  = 10,
  parameter int unsigned PtrW   = 11,
  parameter int unsigned BankW  = 8,
  parameter int unsigned CellId = 0
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  chkim_pkg::tok_ctl_t      tok_ctl_i,
  input  logic [chkim_pkg::KeyW-1:0] tok_key_i,
  input  logic [PtrW-1:0]          tok_ptr_i,
  input  logic [PtrW-1:0]          tok_link_i,
  output chkim_pkg::tok_ctl_t      tok_ctl_o,
  output logic [chkim_pkg::KeyW-1:0] tok_key_o,
  output logic [PtrW-1:0]          tok_ptr_o,
  output logic [PtrW-1:0]          tok_link_o
);
  import chkim_pkg::*;

  localparam int unsigned CellW     = SlotW - BankW;
  localparam int unsigned BankDepth = 1 << BankW;

  typedef enum logic [2:0] {
    CellIdle  = 3'b001,
    CellCheck = 3'b010,
    CellCmp   = 3'b100
  } cell_state_e;

  cell_state_e state_q, state_d;
  tok_ctl_t    ctl_q, ctl_d;
  logic [KeyW-1:0] key_q, key_d;
  logic [PtrW-1:0] ptr_q, ptr_d;
  logic [PtrW-1:0] link_q, link_d;

  logic [KeyW-1:0] keys_mem  [BankDepth];
  logic [PtrW-1:0] links_mem [BankDepth];
  logic [KeyW-1:0] rd_key_q;
  logic [PtrW-1:0] rd_link_q;

  logic             own;
  logic             mem_we;
  logic             mem_re;
  logic [BankW-1:0] laddr;
  logic             hit;
  logic             same_bkt;

  // a live pointer is always below the slot count, so its top bits name the bank
  assign own   = !ctl_q.done && (ptr_q[SlotW-1 -: CellW] == CellW'(CellId));
  assign laddr = ptr_q[BankW-1:0];

  assign hit      = (rd_key_q == key_q);
  assign same_bkt = (rd_key_q[SlotW-1:0] == key_q[SlotW-1:0]);

  always_comb begin
    state_d = state_q;
    ctl_d   = ctl_q;
    key_d   = key_q;
    ptr_d   = ptr_q;
    link_d  = link_q;
    mem_we  = 1'b0;
    mem_re  = 1'b0;
    unique case (state_q)
      CellIdle: begin
        if (tok_ctl_i.vld) begin
          ctl_d   = tok_ctl_i;
          key_d   = tok_key_i;
          ptr_d   = tok_ptr_i;
          link_d  = tok_link_i;
          state_d = CellCheck;
        end
      end
      CellCheck: begin
        if (own && ctl_q.wr) begin
          mem_we      = 1'b1;
          ctl_d.found = 1'b1;
          ctl_d.done  = 1'b1;
        end else if (own) begin
          mem_re  = 1'b1;
          state_d = CellCmp;
        end else begin
          state_d = CellIdle;
        end
      end
      CellCmp: begin
        // stale heads and links from before a clear fail the order or bucket test
        if (hit) begin
          ctl_d.found = 1'b1;
          ctl_d.done  = 1'b1;
        end else if (!same_bkt || (rd_link_q >= ptr_q)) begin
          ctl_d.done = 1'b1;
        end else begin
          ptr_d = rd_link_q;
        end
        state_d = CellCheck;
      end
      default: state_d = CellIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CellIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ctl_q  <= ctl_d;
    key_q  <= key_d;
    ptr_q  <= ptr_d;
    link_q <= link_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      keys_mem[laddr]  <= key_q;
      links_mem[laddr] <= link_q;
    end
    if (mem_re) begin
      rd_key_q  <= keys_mem[laddr];
      rd_link_q <= links_mem[laddr];
    end
  end

  always_comb begin
    tok_ctl_o     = ctl_q;
    tok_ctl_o.vld = (state_q == CellCheck) && !own;
  end

  assign tok_key_o  = key_q;
  assign tok_ptr_o  = ptr_q;
  assign tok_link_o = link_q;

endmodule

[design/chained_hash_key_index_map.sv]
// Key to insertion-order map with separate chaining. Slot storage is split
// into 2**CELL_BITS banks, one per cell in a row; a request token enters the
// highest-slot cell and moves one cell per cycle while no cell holds it to
// work on its own bank, and since chains run from newer to older slots a
// lookup walk visits the row once, a cell reading its own bank for as long
// as the chain stays there. One item is in flight at a time; the next input
// is taken while a result waits on out_stall_i. Clear only zeroes the entry
// count: stale chain heads are rejected on the fly. After reset the bucket
// memory is swept once, with in_stall_o high.
// TABLE_SLOTS: 8..1024. CELL_BITS: 1..$clog2(TABLE_SLOTS)-1.
module chained_hash_key_index_map #(
  parameter int unsigned TABLE_SLOTS = 1024,
  parameter int unsigned CELL_BITS   = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  chkim_pkg::in_item_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output chkim_pkg::out_item_t out_data_o
);
  import chkim_pkg::*;

  localparam int unsigned SlotW    = $clog2(TABLE_SLOTS);
  localparam int unsigned PtrW     = $clog2(TABLE_SLOTS + 1);
  localparam int unsigned NumCells = 1 << CELL_BITS;
  localparam int unsigned BankW    = SlotW - CELL_BITS;
  localparam int unsigned BktDepth = 1 << SlotW;

  typedef enum logic [4:0] {
    StInit = 5'b00001,
    StIdle = 5'b00010,
    StHead = 5'b00100,
    StRow  = 5'b01000,
    StDone = 5'b10000
  } state_e;

  state_e          state_q, state_d;
  logic [SlotW-1:0] init_q, init_d;
  logic [PtrW-1:0] count_q, count_d;
  in_item_t        req_q, req_d;
  out_item_t       res_q, res_d;
  out_item_t       out_q, out_d;
  logic            out_vld_q, out_vld_d;

  logic [PtrW-1:0] heads_mem [BktDepth];
  logic [PtrW-1:0] head_q;
  logic             hd_re;
  logic             hd_we;
  logic [SlotW-1:0] hd_waddr;
  logic [PtrW-1:0]  hd_wdata;

  tok_ctl_t        row_ctl  [NumCells+1];
  logic [KeyW-1:0] row_key  [NumCells+1];
  logic [PtrW-1:0] row_ptr  [NumCells+1];
  logic [PtrW-1:0] row_link [NumCells+1];

  logic in_acc;
  logic full;

  assign in_acc = in_valid_i && (state_q == StIdle);
  assign full   = (count_q == PtrW'(TABLE_SLOTS));

  always_comb begin
    state_d   = state_q;
    init_d    = init_q;
    count_d   = count_q;
    req_d     = req_q;
    res_d     = res_q;
    out_d     = out_q;
    out_vld_d = out_vld_q && out_stall_i;
    hd_re     = 1'b0;
    hd_we     = 1'b0;
    hd_waddr  = req_q.key[SlotW-1:0];
    hd_wdata  = count_q;
    row_ctl[0]  = '0;
    row_key[0]  = req_q.key;
    row_ptr[0]  = count_q;
    row_link[0] = head_q;
    unique case (state_q)
      StInit: begin
        hd_we    = 1'b1;
        hd_waddr = init_q;
        hd_wdata = PtrW'(TABLE_SLOTS);
        init_d   = init_q + 1'b1;
        if (init_q == '1) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (in_acc) begin
          req_d = in_data_i;
          res_d = '0;
          unique case (in_data_i.command)
            CmdInsert: begin
              if (full) begin
                res_d.full_error = 1'b1;
                state_d          = StDone;
              end else begin
                hd_re   = 1'b1;
                state_d = StHead;
              end
            end
            CmdLookup: begin
              hd_re   = 1'b1;
              state_d = StHead;
            end
            CmdClear: begin
              count_d = '0;
              state_d = StDone;
            end
            default: state_d = StDone;
          endcase
        end
      end
      StHead: begin
        row_ctl[0].vld = 1'b1;
        if (req_q.command == CmdInsert) begin
          row_ctl[0].wr = 1'b1;
          hd_we         = 1'b1;
          count_d       = count_q + 1'b1;
        end else begin
          row_ptr[0]      = head_q;
          row_ctl[0].done = (head_q >= count_q);
        end
        state_d = StRow;
      end
      StRow: begin
        if (row_ctl[NumCells].vld) begin
          res_d.found      = row_ctl[NumCells].found;
          res_d.value      = row_ctl[NumCells].found ? ValueW'(row_ptr[NumCells]) : '0;
          res_d.full_error = 1'b0;
          state_d          = StDone;
        end
      end
      StDone: begin
        if (!out_vld_q || !out_stall_i) begin
          out_d     = res_q;
          out_vld_d = 1'b1;
          state_d   = StIdle;
        end
      end
      default: state_d = StInit;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StInit;
      init_q    <= '0;
      count_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      init_q    <= init_d;
      count_q   <= count_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (hd_we) begin
      heads_mem[hd_waddr] <= hd_wdata;
    end
    if (hd_re) begin
      head_q <= heads_mem[in_data_i.key[SlotW-1:0]];
    end
  end

  // cell 0 holds the highest bank
  for (genvar g = 0; g < NumCells; g++) begin : g_cell
    chkim_cell #(
      .SlotW  (SlotW),
      .PtrW   (PtrW),
      .BankW  (BankW),
      .CellId (NumCells - 1 - g)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .tok_ctl_i  (row_ctl[g]),
      .tok_key_i  (row_key[g]),
      .tok_ptr_i  (row_ptr[g]),
      .tok_link_i (row_link[g]),
      .tok_ctl_o  (row_ctl[g+1]),
      .tok_key_o  (row_key[g+1]),
      .tok_ptr_o  (row_ptr[g+1]),
      .tok_link_o (row_link[g+1])
    );
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

[design/chkim_checker.sv]
module chkim_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input chkim_pkg::in_item_t  in_data_i,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input chkim_pkg::out_item_t out_data_o
);
  import chkim_pkg::*;

  // one item in flight: a transfer closes the input until its result is out
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken twice in a row");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  a_found_xor_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.found && out_data_o.full_error))
    else $error("found and full_error both set");

  a_miss_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.found |-> out_data_o.value == '0)
    else $error("nonzero value without a hit");

endmodule

bind chained_hash_key_index_map chkim_checker u_chkim_checker (.*);
